FILE: hw/rtl/pat_pkg.sv
// Shared types and constants for the polyline arrow tessellator.
package pat_pkg;

  // Fixed-point format of coordinates and registers
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CW        = 21;            // register width
  localparam int unsigned XW        = 32;            // coordinate width
  localparam int unsigned DW        = XW + 1;        // difference width
  localparam int unsigned MW        = 30;            // normalized magnitude width
  localparam int unsigned ROOT_W    = 2 * MW + 2;    // square-root work width
  localparam int unsigned ROOT_N    = MW + 1;        // square-root steps
  localparam int unsigned LW        = MW + 1;        // length width
  localparam int unsigned QW        = FRAC_BITS + 1; // tangent magnitude width
  localparam int unsigned NW        = MW + FRAC_BITS + 1; // dividend width
  localparam int unsigned PW        = CW + 1;        // product width
  localparam int unsigned VW        = XW + 3;        // vertex sum width
  localparam int unsigned CNTW      = $clog2(ROOT_N + QW);
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned NCORNER   = 7;

  localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};

  // Register reset values: 0.05, 0.15 and 0.2 in fixed point
  localparam longint unsigned W_RAW = ((64'd1 << FRAC_BITS) + 64'd10) / 64'd20;
  localparam longint unsigned H_RAW = ((64'd3 << FRAC_BITS) + 64'd10) / 64'd20;
  localparam longint unsigned L_RAW = ((64'd1 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [CW-1:0] W_RST = (W_RAW > 64'(CFG_MAX)) ? CFG_MAX : CW'(W_RAW);
  localparam logic [CW-1:0] H_RST = (H_RAW > 64'(CFG_MAX)) ? CFG_MAX : CW'(H_RAW);
  localparam logic [CW-1:0] L_RST = (L_RAW > 64'(CFG_MAX)) ? CFG_MAX : CW'(L_RAW);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHAFT_W = 2'd0,
    CFG_HEAD_W  = 2'd1,
    CFG_HEAD_L  = 2'd2
  } cfg_idx_e;

  // Corner codes of one arrow
  typedef enum logic [2:0] {
    CRN_A_PW = 3'd0,
    CRN_A_MW = 3'd1,
    CRN_C_PW = 3'd2,
    CRN_C_MW = 3'd3,
    CRN_C_PH = 3'd4,
    CRN_C_MH = 3'd5,
    CRN_B    = 3'd6
  } corner_e;

  typedef struct packed {
    logic [CW-1:0] shaft_w;
    logic [CW-1:0] head_w;
    logic [CW-1:0] head_l;
  } cfg_t;

  // One segment from a to b
  typedef struct packed {
    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] ay;
    logic signed [XW-1:0] bx;
    logic signed [XW-1:0] by;
  } seg_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

FILE: hw/rtl/pat_fifo.sv
// Two-entry segment queue between the front and the back.
module pat_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pat_pkg::seg_t  push_data_i,
  input  logic           pop_i,
  output pat_pkg::seg_t  head_o,
  output pat_pkg::q_stat_t stat_o
);
  import pat_pkg::*;

  localparam int unsigned PTRW = $clog2(FIFO_DEPTH);
  localparam int unsigned CNTQ = $clog2(FIFO_DEPTH + 1);

  seg_t             mem_q [FIFO_DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNTQ-1:0]  count_q;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store pushed segments
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNTQ'(FIFO_DEPTH));
  assign stat_o.valid = (count_q != '0);

endmodule

FILE: hw/rtl/pat_front.sv
// Point intake: keeps the previous point and queues segments.
module pat_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pat_pkg::XW-1:0]     point_x_i,
  input  logic signed [pat_pkg::XW-1:0]     point_y_i,
  input  logic                              starts_polyline_i,
  input  pat_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output pat_pkg::seg_t                     seg_o
);
  import pat_pkg::*;

  logic signed [XW-1:0] prev_x_q, prev_y_q;
  logic                 have_prev_q;
  logic                 accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = accept && have_prev_q && !starts_polyline_i;

  assign seg_o.ax = prev_x_q;
  assign seg_o.ay = prev_y_q;
  assign seg_o.bx = point_x_i;
  assign seg_o.by = point_y_i;

  // Hold the previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else if (accept) begin
      prev_x_q    <= point_x_i;
      prev_y_q    <= point_y_i;
      have_prev_q <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/pat_back.sv
// Segment engine: normalize, square root, divide, scale and emit seven vertices.
module pat_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pat_pkg::cfg_t                 cfg_i,
  input  pat_pkg::q_stat_t              q_stat_i,
  input  pat_pkg::seg_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pat_pkg::XW-1:0] vertex_x_o,
  output logic signed [pat_pkg::XW-1:0] vertex_y_o,
  output logic [2:0]                    corner_o,
  output logic                          degenerate_o,
  output logic                          last_o
);
  import pat_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_NORM = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_ROOT = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_CPT  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  localparam int unsigned SQW = 2 * MW;

  function automatic logic signed [XW-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi, lo;
    hi = VW'({1'b0, {(XW-1){1'b1}}});
    lo = -hi - VW'(1);
    if (v > hi) begin
      sat = {1'b0, {(XW-1){1'b1}}};
    end else if (v < lo) begin
      sat = {1'b1, {(XW-1){1'b0}}};
    end else begin
      sat = v[XW-1:0];
    end
  endfunction

  state_e               state_q;
  seg_t                 seg_q;
  logic                 sx_q, sy_q, degen_q;
  logic [DW-1:0]        mx_q, my_q;
  logic [CNTW-1:0]      cnt_q;
  logic [SQW:0]         sq_acc_q;
  logic [ROOT_W-1:0]    rem_q, res_q;
  logic                 dsel_q, dinit_q;
  logic [LW-1:0]        drem_q;
  logic [QW-1:0]        dlo_q, dq_q, qx_q, qy_q;
  logic [PW-1:0]        p_q [6];
  logic signed [VW-1:0] cx_q, cy_q;
  logic [2:0]           crn_q;

  logic                 out_valid_q, degen_o_q, last_o_q;
  logic signed [XW-1:0] vx_q, vy_q;
  logic [2:0]           corner_o_q;

  // Segment difference at the queue head
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        amx, amy, mmax;
  assign dx   = DW'(head_i.bx) - DW'(head_i.ax);
  assign dy   = DW'(head_i.by) - DW'(head_i.ay);
  assign amx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign amy  = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign mmax = (mx_q > my_q) ? mx_q : my_q;

  // Shared squarer
  logic [MW-1:0]  sq_op;
  logic [SQW-1:0] sq_prod;
  assign sq_op   = (cnt_q[0]) ? my_q[MW-1:0] : mx_q[MW-1:0];
  assign sq_prod = sq_op * sq_op;

  // One step of the bitwise square root
  logic [ROOT_W-1:0] rbit, rtry;
  assign rbit = ROOT_W'(1) << {cnt_q, 1'b0};
  assign rtry = res_q + rbit;

  // One step of the restoring divider
  logic [LW:0]    dsh;
  logic           dge;
  logic [NW-1:0]  dnum;
  logic [LW-1:0]  dlen;
  assign dlen = res_q[LW-1:0];
  assign dnum = {(dsel_q ? my_q[MW-1:0] : mx_q[MW-1:0]), {FRAC_BITS{1'b0}}} + NW'(dlen >> 1);
  assign dsh  = {drem_q, dlo_q[QW-1]};
  assign dge  = (dsh >= {1'b0, dlen});

  // Shared scaling multiplier
  logic [CW-1:0]       m_reg;
  logic [QW-1:0]       m_val;
  logic [CW+QW-1:0]    m_prod;
  logic [CW+QW:0]      m_rnd;
  always_comb begin
    case (cnt_q[2:0])
      3'd0, 3'd1: m_reg = cfg_i.head_l;
      3'd2, 3'd3: m_reg = cfg_i.shaft_w;
      default:    m_reg = cfg_i.head_w;
    endcase
  end
  assign m_val  = cnt_q[0] ? qy_q : qx_q;
  assign m_prod = m_reg * m_val;
  assign m_rnd  = (CW+QW+1)'(m_prod) + ((CW+QW+1)'(1) << (FRAC_BITS - 1));

  // Signed offsets along the tangent and normal
  function automatic logic signed [VW-1:0] sgn(input logic neg, input logic [PW-1:0] p);
    logic signed [VW-1:0] v;
    v   = VW'(p);
    sgn = neg ? -v : v;
  endfunction

  logic signed [VW-1:0] wnx, wny, hnx, hny;
  assign wnx = sgn(!sy_q, p_q[3]);
  assign wny = sgn(sx_q,  p_q[2]);
  assign hnx = sgn(!sy_q, p_q[5]);
  assign hny = sgn(sx_q,  p_q[4]);

  // Select the vertex for the current corner
  logic signed [VW-1:0] bsx, bsy, ofx, ofy, vx, vy;
  logic                 vsub;
  always_comb begin
    bsx  = cx_q;
    bsy  = cy_q;
    ofx  = wnx;
    ofy  = wny;
    vsub = 1'b0;
    case (crn_q)
      CRN_A_PW: begin
        bsx = VW'(seg_q.ax);
        bsy = VW'(seg_q.ay);
      end
      CRN_A_MW: begin
        bsx  = VW'(seg_q.ax);
        bsy  = VW'(seg_q.ay);
        vsub = 1'b1;
      end
      CRN_C_PW: ;
      CRN_C_MW: vsub = 1'b1;
      CRN_C_PH: begin
        ofx = hnx;
        ofy = hny;
      end
      CRN_C_MH: begin
        ofx  = hnx;
        ofy  = hny;
        vsub = 1'b1;
      end
      default: begin
        bsx = VW'(seg_q.bx);
        bsy = VW'(seg_q.by);
        ofx = '0;
        ofy = '0;
      end
    endcase
    vx = vsub ? bsx - ofx : bsx + ofx;
    vy = vsub ? bsy - ofy : bsy + ofy;
  end

  logic out_load;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == ST_IDLE) && q_stat_i.valid;

  // Sequence one segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dsel_q  <= 1'b0;
      dinit_q <= 1'b0;
      crn_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_stat_i.valid) begin
            cnt_q   <= '0;
            state_q <= (amx == '0 && amy == '0) ? ST_MUL : ST_NORM;
          end
        end
        ST_NORM: begin
          if (mmax[DW-1:MW] == '0 && mmax[MW-1]) begin
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[0]) begin
            cnt_q   <= CNTW'(ROOT_N - 1);
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            dsel_q  <= 1'b0;
            dinit_q <= 1'b1;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dinit_q) begin
            dinit_q <= 1'b0;
            cnt_q   <= CNTW'(QW - 1);
          end else begin
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == '0) begin
              if (!dsel_q) begin
                dsel_q  <= 1'b1;
                dinit_q <= 1'b1;
              end else begin
                cnt_q   <= '0;
                state_q <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(5)) begin
            state_q <= ST_CPT;
          end
        end
        ST_CPT: begin
          crn_q   <= CRN_A_PW;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            crn_q <= crn_q + 1'b1;
            if (crn_q == CRN_B) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        seg_q    <= head_i;
        sx_q     <= dx[DW-1];
        sy_q     <= dy[DW-1];
        mx_q     <= amx;
        my_q     <= amy;
        degen_q  <= (amx == '0 && amy == '0);
        qx_q     <= '0;
        qy_q     <= '0;
        sq_acc_q <= '0;
      end
      ST_NORM: begin
        if (mmax[DW-1:MW] != '0) begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
        end else if (!mmax[MW-1]) begin
          mx_q <= mx_q << 1;
          my_q <= my_q << 1;
        end
      end
      ST_SQ: begin
        sq_acc_q <= sq_acc_q + (SQW+1)'(sq_prod);
        rem_q    <= ROOT_W'(sq_acc_q + (SQW+1)'(sq_prod));
        res_q    <= '0;
      end
      ST_ROOT: begin
        if (rem_q >= rtry) begin
          rem_q <= rem_q - rtry;
          res_q <= (res_q >> 1) + rbit;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      ST_DIV: begin
        if (dinit_q) begin
          drem_q <= LW'(dnum[NW-1:QW]);
          dlo_q  <= dnum[QW-1:0];
          dq_q   <= '0;
        end else begin
          drem_q <= dge ? LW'(dsh - {1'b0, dlen}) : dsh[LW-1:0];
          dlo_q  <= dlo_q << 1;
          dq_q   <= {dq_q[QW-2:0], dge};
          if (cnt_q == '0) begin
            if (!dsel_q) begin
              qx_q <= {dq_q[QW-2:0], dge};
            end else begin
              qy_q <= {dq_q[QW-2:0], dge};
            end
          end
        end
      end
      ST_MUL: begin
        p_q[cnt_q[2:0]] <= m_rnd[FRAC_BITS +: PW];
      end
      ST_CPT: begin
        cx_q <= VW'(seg_q.bx) - sgn(sx_q, p_q[0]);
        cy_q <= VW'(seg_q.by) - sgn(sy_q, p_q[1]);
      end
      default: ;
    endcase
  end

  // Output register: load a vertex, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vx_q       <= sat(vx);
      vy_q       <= sat(vy);
      corner_o_q <= crn_q;
      degen_o_q  <= degen_q;
      last_o_q   <= (crn_q == CRN_B);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_x_o   = vx_q;
  assign vertex_y_o   = vy_q;
  assign corner_o     = corner_o_q;
  assign degenerate_o = degen_o_q;
  assign last_o       = last_o_q;

endmodule

FILE: hw/rtl/polyline_arrow_tessellator.sv
// Top level of the polyline arrow tessellator: registers, front, queue and back.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | point_x, point_y, starts_polyline
//  out     | output    | out_valid_o/out_stall_i | vertex_x, vertex_y, corner, degenerate, last
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// A point that starts a polyline gives no vertex. A segment passes through
// normalizing, two squarings, 31 square-root steps, two divisions, six multiplies,
// the head base and 7 vertex beats; a zero-length segment skips straight to the
// multiplies. The square root and the divider are serial; a two-beat queue lets
// the front take points while the back works. Reset restores the register defaults
// and clears the previous point; an output stall holds the current vertex.
module polyline_arrow_tessellator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [pat_pkg::XW-1:0] point_x_i,
  input  logic signed [pat_pkg::XW-1:0] point_y_i,
  input  logic                          starts_polyline_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pat_pkg::XW-1:0] vertex_x_o,
  output logic signed [pat_pkg::XW-1:0] vertex_y_o,
  output logic [2:0]                    corner_o,
  output logic                          degenerate_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [pat_pkg::CW-1:0]        cfg_data_i
);
  import pat_pkg::*;

  cfg_t    cfg_q;
  q_stat_t q_stat;
  seg_t    push_seg, head_seg;
  logic    push, pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shaft_w <= W_RST;
      cfg_q.head_w  <= H_RST;
      cfg_q.head_l  <= L_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHAFT_W: cfg_q.shaft_w <= cfg_data_i;
        CFG_HEAD_W:  cfg_q.head_w  <= cfg_data_i;
        CFG_HEAD_L:  cfg_q.head_l  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pat_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .starts_polyline_i(starts_polyline_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .seg_o            (push_seg)
  );

  pat_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_seg),
    .pop_i      (pop),
    .head_o     (head_seg),
    .stat_o     (q_stat)
  );

  pat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (head_seg),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_x_o  (vertex_x_o),
    .vertex_y_o  (vertex_y_o),
    .corner_o    (corner_o),
    .degenerate_o(degenerate_o),
    .last_o      (last_o)
  );

endmodule

FILE: hw/rtl/pat_checker.sv
// Port-level checks on the tessellator output, bound to the top level.
module pat_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [pat_pkg::XW-1:0] vertex_x_o,
  input logic signed [pat_pkg::XW-1:0] vertex_y_o,
  input logic [2:0]                    corner_o,
  input logic                          degenerate_o,
  input logic                          last_o
);
  import pat_pkg::*;

  // Last beat is the tip corner
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (corner_o == CRN_B)))
    else $error("last does not match tip corner");

  // Corners of one arrow follow back to back
  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && corner_o == $past(corner_o) + 3'd1))
    else $error("arrow corners out of sequence");

  // Degenerate flag is constant across an arrow
  a_degen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (degenerate_o == $past(degenerate_o)))
    else $error("degenerate flag changed within arrow");

  // Stalled vertex holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(vertex_x_o) && $stable(vertex_y_o) && $stable(corner_o)))
    else $error("stalled vertex changed");

endmodule

bind polyline_arrow_tessellator pat_checker u_pat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .vertex_x_o  (vertex_x_o),
  .vertex_y_o  (vertex_y_o),
  .corner_o    (corner_o),
  .degenerate_o(degenerate_o),
  .last_o      (last_o)
);
